[rtl/core/radar_measurement_jacobian_unit_defines.svh]
// Assertion macros shared by the radar Jacobian checker.
`ifndef RADAR_MEASUREMENT_JACOBIAN_UNIT_DEFINES_SVH
`define RADAR_MEASUREMENT_JACOBIAN_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RMJ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmj check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RMJ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmj check failed");

`endif

[rtl/core/rmj_pkg.sv]
// Shared types, constants and helper functions of the radar Jacobian unit.
package rmj_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int C_W           = 64;
  localparam int ROOT_W        = 32;
  localparam int QUO_W         = 32;
  localparam int MIN_W         = 17;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;
  localparam int SQRT_LAT      = ROOT_W;
  localparam int DIV_LAT       = QUO_W + 1;

  localparam logic [MIN_W-1:0] MIN_R2_RESET = 17'd66;

  // Register index codes, taken from paddr[CFG_AW-1]
  localparam logic REG_MIN_R2 = 1'b0;

  typedef struct packed {
    logic              sx;
    logic              sy;
    logic              xneg;
    logic              refuse;
    logic [DATA_W-1:0] ax;
    logic [DATA_W-1:0] ay;
    logic [C_W-1:0]    xmag;
    logic [C_W-1:0]    c;
  } side_t;

  typedef struct packed {
    logic sx;
    logic sy;
    logic xneg;
    logic refuse;
  } flags_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_dx;
    logic signed [DATA_W-1:0] range_dy;
    logic signed [DATA_W-1:0] bearing_dx;
    logic signed [DATA_W-1:0] bearing_dy;
    logic signed [DATA_W-1:0] rate_dx;
    logic signed [DATA_W-1:0] rate_dy;
    logic                     too_close;
  } result_t;

  // Magnitude of a two's complement word; the most negative value maps to 2^31
  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
  endfunction

  // Apply a sign to a magnitude and clamp to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic neg,
                                                     input logic [C_W-1:0] mag);
    logic signed [DATA_W-1:0] res;
    if (neg) begin
      if (mag >= C_W'(64'h8000_0000)) res = 32'sh8000_0000;
      else                            res = signed'(DATA_W'(0) - mag[DATA_W-1:0]);
    end else begin
      if (mag > C_W'(64'h7FFF_FFFF)) res = 32'sh7FFF_FFFF;
      else                           res = signed'(mag[DATA_W-1:0]);
    end
    return res;
  endfunction

endpackage

[rtl/core/rmj_delay.sv]
// Valid-tagged delay line that carries side data alongside an arithmetic pipe.
module rmj_delay import rmj_pkg::*; #(
  parameter int W     = 4,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic         valid_r [DEPTH];
  logic [W-1:0] data_r  [DEPTH];

  // Advance valid bits, clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) valid_r[k] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int k = 1; k < DEPTH; k++) valid_r[k] <= valid_r[k-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      data_r[0] <= in_data;
      for (int k = 1; k < DEPTH; k++) data_r[k] <= data_r[k-1];
    end
  end

  assign out_valid = valid_r[DEPTH-1];
  assign out_data  = data_r[DEPTH-1];

endmodule

[rtl/core/rmj_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module rmj_sqrt import rmj_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [C_W-1:0]    rad,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int T_W   = REM_W + 2;

  logic [REM_W-1:0]  rem_r [ROOT_W];
  logic [ROOT_W-1:0] q_r   [ROOT_W];
  logic [C_W-1:0]    rad_r [ROOT_W];

  logic [REM_W-1:0]  src_rem [ROOT_W+1];
  logic [ROOT_W-1:0] src_q   [ROOT_W+1];
  logic [C_W-1:0]    src_rad [ROOT_W+1];
  logic [T_W-1:0]    trial   [ROOT_W];
  logic [T_W-1:0]    sub     [ROOT_W];
  logic [T_W-1:0]    diff    [ROOT_W];
  logic              ge      [ROOT_W];

  // Stage inputs: the radicand for the first stage, the previous register after
  always_comb begin
    src_rem[0] = '0;
    src_q[0]   = '0;
    src_rad[0] = rad;
    for (int k = 0; k < ROOT_W; k++) begin
      src_rem[k+1] = rem_r[k];
      src_q[k+1]   = q_r[k];
      src_rad[k+1] = rad_r[k];
    end
  end

  // Try one root bit per stage against the next two radicand bits
  always_comb begin
    for (int k = 0; k < ROOT_W; k++) begin
      trial[k] = {src_rem[k], src_rad[k][C_W-1 -: 2]};
      sub[k]   = T_W'({src_q[k], 2'b01});
      ge[k]    = trial[k] >= sub[k];
      diff[k]  = trial[k] - sub[k];
    end
  end

  // Advance every stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_r[k] <= ge[k] ? diff[k][REM_W-1:0] : trial[k][REM_W-1:0];
        q_r[k]   <= {src_q[k][ROOT_W-2:0], ge[k]};
        rad_r[k] <= {src_rad[k][C_W-3:0], 2'b00};
      end
    end
  end

  assign root = q_r[ROOT_W-1];

endmodule

[rtl/core/rmj_div.sv]
// Pipelined restoring divider: min(floor(num * 2^SH / den), 2^31), one bit per stage.
module rmj_div import rmj_pkg::*; #(
  parameter int NUM_W = 32,
  parameter int SH    = 16,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int NW = NUM_W + SH;
  localparam int HW = NW - QUO_W;
  localparam int CW = ((HW > DEN_W) ? HW : DEN_W) + 1;
  localparam logic [QUO_W-1:0] CAP = QUO_W'(1) << (QUO_W - 1);

  logic [NW-1:0]    n_ext;
  logic [CW-1:0]    hi_x;
  logic [CW-1:0]    den_x;

  logic [DEN_W-1:0] p0_rem_r;
  logic [QUO_W-1:0] p0_lo_r;
  logic [DEN_W-1:0] p0_den_r;
  logic             p0_ovf_r;

  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] lo_r  [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] q_r   [QUO_W];
  logic             ovf_r [QUO_W];

  logic [DEN_W-1:0] src_rem [QUO_W+1];
  logic [QUO_W-1:0] src_lo  [QUO_W+1];
  logic [DEN_W-1:0] src_den [QUO_W+1];
  logic [QUO_W-1:0] src_q   [QUO_W+1];
  logic             src_ovf [QUO_W+1];
  logic [DEN_W:0]   trial   [QUO_W];
  logic [DEN_W:0]   diff    [QUO_W];
  logic             ge      [QUO_W];

  assign n_ext = NW'(num) << SH;
  assign hi_x  = CW'(n_ext[NW-1:QUO_W]);
  assign den_x = CW'(den);

  // Split the shifted dividend and flag quotients of 2^32 or more
  always_ff @(posedge clk) begin
    if (en) begin
      p0_rem_r <= hi_x[DEN_W-1:0];
      p0_lo_r  <= n_ext[QUO_W-1:0];
      p0_den_r <= den;
      p0_ovf_r <= hi_x >= den_x;
    end
  end

  always_comb begin
    src_rem[0] = p0_rem_r;
    src_lo[0]  = p0_lo_r;
    src_den[0] = p0_den_r;
    src_q[0]   = '0;
    src_ovf[0] = p0_ovf_r;
    for (int k = 0; k < QUO_W; k++) begin
      src_rem[k+1] = rem_r[k];
      src_lo[k+1]  = lo_r[k];
      src_den[k+1] = den_r[k];
      src_q[k+1]   = q_r[k];
      src_ovf[k+1] = ovf_r[k];
    end
  end

  // Shift in one dividend bit and subtract where it fits
  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      trial[k] = {src_rem[k], src_lo[k][QUO_W-1]};
      ge[k]    = trial[k] >= {1'b0, src_den[k]};
      diff[k]  = trial[k] - {1'b0, src_den[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k] <= ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
        lo_r[k]  <= {src_lo[k][QUO_W-2:0], 1'b0};
        den_r[k] <= src_den[k];
        q_r[k]   <= {src_q[k][QUO_W-2:0], ge[k]};
        ovf_r[k] <= src_ovf[k];
      end
    end
  end

  // Cap the quotient at 2^31
  assign quo = (ovf_r[QUO_W-1] || (q_r[QUO_W-1] > CAP)) ? CAP : q_r[QUO_W-1];

endmodule

[rtl/core/rmj_skid.sv]
// Two-entry output queue that lets the pipe keep taking items while a result waits.
module rmj_skid import rmj_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop_stall,
  output logic         full,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [1:0]   count_r;
  logic [1:0]   count_nxt;
  logic [W-1:0] head_r;
  logic [W-1:0] tail_r;
  logic         pop;

  assign pop       = (count_r != 2'd0) && !pop_stall;
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = head_r;

  always_comb begin
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  // Track the fill level
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  // Load head from tail or the new item, tail only when head stays occupied
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count_r == 2'd2) head_r <= tail_r;
      else if (push)       head_r <= push_data;
    end else if (push && (count_r == 2'd0)) begin
      head_r <= push_data;
    end
    if (push && !pop && (count_r == 2'd1)) tail_r <= push_data;
  end

endmodule

[rtl/core/radar_measurement_jacobian_unit.sv]
// Radar measurement Jacobian unit: top level with front end, pipes and output stage.
//
// Takes a constant-velocity state (px, py, vx, vy) in signed fixed point with
// FRAC_BITS fraction bits and returns px/r, py/r, -py/r^2, px/r^2 and the two
// range-rate terms, each saturated to 32 bits; if r^2 is below
// min_range_squared (scaled by 2^FRAC_BITS) or zero, all six are zero and
// too_close is set. One item enters per clock while in_stall is low; an item
// passes through magnitude, square and sum, the one-bit-per-stage square root,
// the one-bit-per-stage dividers, the output multiply and the output register
// on its way to out_valid. A two-entry output queue keeps input open while a
// result waits; in_stall rises once it holds two.
// min_range_squared lives at byte address 0, resets to 66, and may only be
// written while no item is in flight.
module radar_measurement_jacobian_unit import rmj_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_pos_x,
  input  logic signed [DATA_W-1:0] in_pos_y,
  input  logic signed [DATA_W-1:0] in_vel_x,
  input  logic signed [DATA_W-1:0] in_vel_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_range_dx,
  output logic signed [DATA_W-1:0] out_range_dy,
  output logic signed [DATA_W-1:0] out_bearing_dx,
  output logic signed [DATA_W-1:0] out_bearing_dy,
  output logic signed [DATA_W-1:0] out_rate_dx,
  output logic signed [DATA_W-1:0] out_rate_dy,
  output logic                     out_too_close,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready
);

  logic             adv;
  logic             skid_full;
  logic [MIN_W-1:0] min_r;

  // front end
  logic              f0_valid_r, f1_valid_r, f2_valid_r;
  logic              f0_sx_r, f0_sy_r, f0_svx_r, f0_svy_r;
  logic [DATA_W-1:0] f0_ax_r, f0_ay_r, f0_avx_r, f0_avy_r;
  logic              f1_sx_r, f1_sy_r, f1_n1_r, f1_n2_r;
  logic [DATA_W-1:0] f1_ax_r, f1_ay_r;
  logic [C_W-1:0]    f1_sqx_r, f1_sqy_r, f1_m1_r, f1_m2_r;
  logic              f2_sx_r, f2_sy_r, f2_xneg_r;
  logic [DATA_W-1:0] f2_ax_r, f2_ay_r;
  logic [C_W-1:0]    f2_c_r, f2_xmag_r;
  logic              f2_xneg_nxt;
  logic [C_W-1:0]    f2_xmag_nxt;
  logic [C_W-1:0]    thr;
  side_t             f2_side;

  // square root and divider stages
  logic              s_valid;
  side_t             s_side;
  logic [ROOT_W-1:0] root;
  flags_t            s_flags;
  logic              d_valid;
  flags_t            d_flags;
  logic [QUO_W-1:0]  q_rdx, q_rdy, q_bdx, q_bdy, q_w;

  // output multiply
  logic                     m1_valid_r, m2_valid_r;
  logic                     m1_refuse_r, m1_xneg_r, m1_n0_r, m1_n1_r;
  logic signed [DATA_W-1:0] m1_v0_r, m1_v1_r, m1_v2_r, m1_v3_r;
  logic [DATA_W-1:0]        m1_a0_r, m1_a1_r, m1_wmag_r;
  logic signed [DATA_W-1:0] v0, v1;
  logic                     m2_refuse_r, m2_ndx_r, m2_ndy_r;
  logic signed [DATA_W-1:0] m2_v0_r, m2_v1_r, m2_v2_r, m2_v3_r;
  logic [C_W-1:0]           m2_pdx_r, m2_pdy_r;
  result_t                  res;
  result_t                  out_res;
  logic [$bits(result_t)-1:0] out_bits;

  // The whole pipe moves while the output queue has room
  assign adv      = !skid_full;
  assign in_stall = skid_full;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_R2_RESET;
    end else if (psel && penable && pwrite && (paddr[CFG_AW-1] == REG_MIN_R2)) begin
      min_r <= pwdata[MIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_AW-1] == REG_MIN_R2) prdata = CFG_DW'(min_r);
  end

  // Valid bits of the front end and the output multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_valid_r <= 1'b0;
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
    end else if (adv) begin
      f0_valid_r <= in_valid;
      f1_valid_r <= f0_valid_r;
      f2_valid_r <= f1_valid_r;
      m1_valid_r <= d_valid;
      m2_valid_r <= m1_valid_r;
    end
  end

  // Combine the two cross products into a signed magnitude
  always_comb begin
    if (f1_n1_r == f1_n2_r) begin
      f2_xmag_nxt = f1_m1_r + f1_m2_r;
      f2_xneg_nxt = f1_n1_r;
    end else if (f1_m1_r >= f1_m2_r) begin
      f2_xmag_nxt = f1_m1_r - f1_m2_r;
      f2_xneg_nxt = f1_n1_r;
    end else begin
      f2_xmag_nxt = f1_m2_r - f1_m1_r;
      f2_xneg_nxt = f1_n2_r;
    end
  end

  // Front end: magnitudes, products, range squared
  always_ff @(posedge clk) begin
    if (adv) begin
      f0_sx_r   <= in_pos_x[DATA_W-1];
      f0_sy_r   <= in_pos_y[DATA_W-1];
      f0_svx_r  <= in_vel_x[DATA_W-1];
      f0_svy_r  <= in_vel_y[DATA_W-1];
      f0_ax_r   <= mag32(in_pos_x);
      f0_ay_r   <= mag32(in_pos_y);
      f0_avx_r  <= mag32(in_vel_x);
      f0_avy_r  <= mag32(in_vel_y);

      f1_sx_r   <= f0_sx_r;
      f1_sy_r   <= f0_sy_r;
      f1_n1_r   <= f0_svx_r != f0_sy_r;
      f1_n2_r   <= f0_svy_r == f0_sx_r;
      f1_ax_r   <= f0_ax_r;
      f1_ay_r   <= f0_ay_r;
      f1_sqx_r  <= C_W'(f0_ax_r) * C_W'(f0_ax_r);
      f1_sqy_r  <= C_W'(f0_ay_r) * C_W'(f0_ay_r);
      f1_m1_r   <= C_W'(f0_avx_r) * C_W'(f0_ay_r);
      f1_m2_r   <= C_W'(f0_avy_r) * C_W'(f0_ax_r);

      f2_sx_r   <= f1_sx_r;
      f2_sy_r   <= f1_sy_r;
      f2_ax_r   <= f1_ax_r;
      f2_ay_r   <= f1_ay_r;
      f2_c_r    <= f1_sqx_r + f1_sqy_r;
      f2_xmag_r <= f2_xmag_nxt;
      f2_xneg_r <= f2_xneg_nxt;
    end
  end

  // Refuse when too close or at zero range
  assign thr = C_W'(min_r) << FRAC_BITS;
  always_comb begin
    f2_side.sx     = f2_sx_r;
    f2_side.sy     = f2_sy_r;
    f2_side.xneg   = f2_xneg_r;
    f2_side.refuse = (f2_c_r < thr) || (f2_c_r == '0);
    f2_side.ax     = f2_ax_r;
    f2_side.ay     = f2_ay_r;
    f2_side.xmag   = f2_xmag_r;
    f2_side.c      = f2_c_r;
  end

  rmj_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (f2_c_r),
    .root (root)
  );

  rmj_delay #(.W($bits(side_t)), .DEPTH(SQRT_LAT)) u_dly_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (f2_valid_r),
    .in_data   (f2_side),
    .out_valid (s_valid),
    .out_data  (s_side)
  );

  assign s_flags.sx     = s_side.sx;
  assign s_flags.sy     = s_side.sy;
  assign s_flags.xneg   = s_side.xneg;
  assign s_flags.refuse = s_side.refuse;

  rmj_delay #(.W($bits(flags_t)), .DEPTH(DIV_LAT)) u_dly_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s_valid),
    .in_data   (s_flags),
    .out_valid (d_valid),
    .out_data  (d_flags)
  );

  rmj_div #(.NUM_W(DATA_W), .SH(FRAC_BITS), .DEN_W(ROOT_W)) u_div_rdx (
    .clk (clk), .en (adv), .num (s_side.ax), .den (root), .quo (q_rdx)
  );

  rmj_div #(.NUM_W(DATA_W), .SH(FRAC_BITS), .DEN_W(ROOT_W)) u_div_rdy (
    .clk (clk), .en (adv), .num (s_side.ay), .den (root), .quo (q_rdy)
  );

  rmj_div #(.NUM_W(DATA_W), .SH(2 * FRAC_BITS), .DEN_W(C_W)) u_div_bdx (
    .clk (clk), .en (adv), .num (s_side.ay), .den (s_side.c), .quo (q_bdx)
  );

  rmj_div #(.NUM_W(DATA_W), .SH(2 * FRAC_BITS), .DEN_W(C_W)) u_div_bdy (
    .clk (clk), .en (adv), .num (s_side.ax), .den (s_side.c), .quo (q_bdy)
  );

  rmj_div #(.NUM_W(C_W), .SH(FRAC_BITS), .DEN_W(C_W)) u_div_w (
    .clk (clk), .en (adv), .num (s_side.xmag), .den (s_side.c), .quo (q_w)
  );

  // Sign and clamp the quotients, take magnitudes for the rate products
  assign v0 = sat32(d_flags.sx, C_W'(q_rdx));
  assign v1 = sat32(d_flags.sy, C_W'(q_rdy));

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_refuse_r <= d_flags.refuse;
      m1_xneg_r   <= d_flags.xneg;
      m1_v0_r     <= v0;
      m1_v1_r     <= v1;
      m1_v2_r     <= sat32(!d_flags.sy, C_W'(q_bdx));
      m1_v3_r     <= sat32(d_flags.sx, C_W'(q_bdy));
      m1_a0_r     <= mag32(v0);
      m1_a1_r     <= mag32(v1);
      m1_n0_r     <= v0[DATA_W-1];
      m1_n1_r     <= v1[DATA_W-1];
      m1_wmag_r   <= q_w;

      m2_refuse_r <= m1_refuse_r;
      m2_v0_r     <= m1_v0_r;
      m2_v1_r     <= m1_v1_r;
      m2_v2_r     <= m1_v2_r;
      m2_v3_r     <= m1_v3_r;
      m2_pdx_r    <= C_W'(m1_a1_r) * C_W'(m1_wmag_r);
      m2_pdy_r    <= C_W'(m1_a0_r) * C_W'(m1_wmag_r);
      m2_ndx_r    <= m1_n1_r != m1_xneg_r;
      m2_ndy_r    <= m1_n0_r == m1_xneg_r;
    end
  end

  // Scale the rate products, zero everything on refusal
  always_comb begin
    res.too_close  = m2_refuse_r;
    res.range_dx   = m2_refuse_r ? '0 : m2_v0_r;
    res.range_dy   = m2_refuse_r ? '0 : m2_v1_r;
    res.bearing_dx = m2_refuse_r ? '0 : m2_v2_r;
    res.bearing_dy = m2_refuse_r ? '0 : m2_v3_r;
    res.rate_dx    = m2_refuse_r ? '0 : sat32(m2_ndx_r, m2_pdx_r >> FRAC_BITS);
    res.rate_dy    = m2_refuse_r ? '0 : sat32(m2_ndy_r, m2_pdy_r >> FRAC_BITS);
  end

  rmj_skid #(.W($bits(result_t))) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && m2_valid_r),
    .push_data (res),
    .pop_stall (out_stall),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_data  (out_bits)
  );

  assign out_res        = out_bits;
  assign out_range_dx   = out_res.range_dx;
  assign out_range_dy   = out_res.range_dy;
  assign out_bearing_dx = out_res.bearing_dx;
  assign out_bearing_dy = out_res.bearing_dy;
  assign out_rate_dx    = out_res.rate_dx;
  assign out_rate_dy    = out_res.rate_dy;
  assign out_too_close  = out_res.too_close;

endmodule

[rtl/core/rmj_checker.sv]
// Port-level checker for the radar Jacobian unit, bound to the top level.
`include "radar_measurement_jacobian_unit_defines.svh"

module rmj_checker import rmj_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_range_dx,
  input logic signed [DATA_W-1:0] out_range_dy,
  input logic signed [DATA_W-1:0] out_bearing_dx,
  input logic signed [DATA_W-1:0] out_bearing_dy,
  input logic signed [DATA_W-1:0] out_rate_dx,
  input logic signed [DATA_W-1:0] out_rate_dy,
  input logic                     out_too_close
);

  // Hold a stalled result
  `RMJ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_range_dx) && $stable(out_too_close))

  // A refused item carries all-zero entries
  `RMJ_ASSERT_IMP(a_refuse_zero, out_valid && out_too_close, out_range_dx == '0 && out_range_dy == '0 && out_bearing_dx == '0 && out_bearing_dy == '0 && out_rate_dx == '0 && out_rate_dy == '0)

  // Never stall input with an empty output queue
  `RMJ_ASSERT_IMP(a_no_idle_stall, !out_valid, !in_stall)

  // px/r and px/r^2 share the sign of px
  `RMJ_ASSERT_IMP(a_px_sign, out_valid && out_range_dx != '0 && out_bearing_dy != '0, out_range_dx[DATA_W-1] == out_bearing_dy[DATA_W-1])

endmodule

bind radar_measurement_jacobian_unit rmj_checker u_rmj_checker (.*);

[tb/tb_top.sv]
// Testbench for the radar measurement Jacobian unit: scoreboard, drivers and checks.
`timescale 1ns / 100ps

module tb_top;
  import rmj_pkg::*;

  localparam int FRAC = 16;
  localparam logic [63:0] CAP = 64'h8000_0000;
  localparam logic [2:0] ADDR_MIN_R2 = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam int LIMIT = 400000;

  // Predict and check Jacobian results in acceptance order
  class jacobian_board;
    logic [MIN_W-1:0] min_r2;
    result_t pending_jacobians[$];
    int errors;

    function new();
      min_r2 = MIN_R2_RESET;
      errors = 0;
    endfunction

    function logic [63:0] magnitude(logic [31:0] v);
      return v[31] ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
    endfunction

    function logic [31:0] clamp(logic neg, logic [63:0] m);
      if (neg) return (m >= CAP) ? 32'h8000_0000 : 32'(64'd0 - m);
      return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    // floor(num * 2^sh / den), capped at 2^31
    function logic [63:0] scaled_quot(logic [63:0] num, int sh, logic [63:0] den);
      logic [63:0] q, rem;
      q = num / den;
      rem = num % den;
      if (q > CAP) return CAP;
      for (int i = 0; i < sh; i++) begin
        q = q << 1;
        rem = rem << 1;
        if (rem >= den) begin
          rem = rem - den;
          q = q + 1;
        end
        if (q > CAP) return CAP;
      end
      return q;
    endfunction

    function logic [63:0] int_root(logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic [31:0] scale_by(logic [31:0] a, logic wneg, logic [63:0] wmag);
      logic [63:0] prod;
      prod = magnitude(a) * wmag;
      return clamp(a[31] != wneg, prod >> FRAC);
    endfunction

    // Compute the expected entries for one accepted state
    function void note_state(logic [31:0] px, logic [31:0] py,
                             logic [31:0] vx, logic [31:0] vy);
      result_t e;
      logic [63:0] ax, ay, avx, avy, c, r, m1, m2, xmag, wmag;
      logic n1, n2, xneg;
      ax = magnitude(px);
      ay = magnitude(py);
      avx = magnitude(vx);
      avy = magnitude(vy);
      c = ax * ax + ay * ay;
      r = int_root(c);
      e = '0;
      if (c < ({47'b0, min_r2} << FRAC) || r == 0) begin
        e.too_close = 1'b1;
      end else begin
        e.range_dx = clamp(px[31], scaled_quot(ax, FRAC, r));
        e.range_dy = clamp(py[31], scaled_quot(ay, FRAC, r));
        e.bearing_dx = clamp(!py[31], scaled_quot(ay, 2 * FRAC, c));
        e.bearing_dy = clamp(px[31], scaled_quot(ax, 2 * FRAC, c));
        // cross term vx*py - vy*px as sign and magnitude
        m1 = avx * ay;
        n1 = vx[31] != py[31];
        m2 = avy * ax;
        n2 = vy[31] == px[31];
        if (n1 == n2) begin
          xmag = m1 + m2;
          xneg = n1;
        end else if (m1 >= m2) begin
          xmag = m1 - m2;
          xneg = n1;
        end else begin
          xmag = m2 - m1;
          xneg = n2;
        end
        wmag = scaled_quot(xmag, FRAC, c);
        e.rate_dx = scale_by(e.range_dy, xneg, wmag);
        e.rate_dy = scale_by(e.range_dx, !xneg, wmag);
      end
      pending_jacobians.push_back(e);
    endfunction

    function void report(string what, result_t e, result_t a);
      errors++;
      if (errors <= 10)
        $display("%0t mismatch %s: expected %h actual %h", $realtime, what, e, a);
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (pending_jacobians.size() == 0) begin
        report("unexpected item", '0, a);
        return;
      end
      e = pending_jacobians.pop_front();
      if (a.range_dx !== e.range_dx) report("range_dx", e, a);
      if (a.range_dy !== e.range_dy) report("range_dy", e, a);
      if (a.bearing_dx !== e.bearing_dx) report("bearing_dx", e, a);
      if (a.bearing_dy !== e.bearing_dy) report("bearing_dy", e, a);
      if (a.rate_dx !== e.rate_dx) report("rate_dx", e, a);
      if (a.rate_dy !== e.rate_dy) report("rate_dy", e, a);
      if (a.too_close !== e.too_close) report("too_close", e, a);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_range_dx, out_range_dy, out_bearing_dx, out_bearing_dy;
  logic signed [31:0] out_rate_dx, out_rate_dy;
  logic out_too_close;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  jacobian_board board = new();
  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycles = 0;

  radar_measurement_jacobian_unit dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 7) : 0;
  endfunction

  // Check each accepted result and draw the next stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      board.check_result({out_range_dx, out_range_dy, out_bearing_dx, out_bearing_dy,
                          out_rate_dx, out_rate_dy, out_too_close});
      stall_left = draw_wait();
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= (stall_left != 0);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one item, after a random gap while idle_on is set, and hold it until accepted
  task automatic send_state(logic [31:0] px, logic [31:0] py,
                            logic [31:0] vx, logic [31:0] vy);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_vel_x <= vx;
    in_vel_y <= vy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_state(px, py, vx, vy);
  endtask

  // Drop valid right after the last accepted item and wait for every result
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_jacobians.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MIN_R2) board.min_r2 = value[MIN_W-1:0];
  endtask

  function automatic logic [31:0] rand_field();
    return $unsigned($signed($urandom) >>> $urandom_range(0, 31));
  endfunction

  task automatic random_states(int n);
    logic [31:0] px, py;
    repeat (n) begin
      px = rand_field();
      py = rand_field();
      // keep some items near the threshold
      if ($urandom_range(0, 3) == 0) begin
        px = $unsigned($signed(px) >>> 12);
        py = $unsigned($signed(py) >>> 12);
      end
      send_state(px, py, rand_field(), rand_field());
    end
  endtask

  initial begin
    logic [31:0] phase_thr[6];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, extremes, signs, below default threshold
    send_state(0, 0, 0, 0);
    send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_state(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_state(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_state(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
    send_state(32'hFFFE_0000, 32'h0003_0000, 32'hFFFF_8000, 32'h0000_4000);
    send_state(32'd2000, 32'd500, 32'hFFFF_FFFF, 32'd1);
    send_state(32'd2080, 0, 32'd5, 32'd7);
    drain();

    // zero threshold: zero range and tiny ranges
    write_reg(ADDR_MIN_R2, 32'd0);
    send_state(0, 0, 32'h1234_5678, 32'h8765_4321);
    send_state(32'd1, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_state(0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000);
    send_state(32'd3, 32'd4, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();

    // threshold 65536: r^2 exactly at and just below it
    write_reg(ADDR_MIN_R2, 32'd65536);
    send_state(32'h0001_0000, 0, 32'd1, 32'd1);
    send_state(32'h0000_FFFF, 0, 32'd1, 32'd1);
    send_state(0, 32'hFFFF_0000, 32'h0000_1000, 32'hFFFF_F000);
    drain();

    // write to an unused address is ignored
    write_reg(ADDR_UNUSED, 32'd5);
    send_state(32'h0000_FFFF, 32'd0, 32'd9, 32'd9);
    drain();

    // random phases over several thresholds, idling on and off
    phase_thr[0] = 32'd66;
    phase_thr[1] = 32'd0;
    phase_thr[2] = 32'd65536;
    phase_thr[3] = $urandom_range(0, 65536);
    phase_thr[4] = 32'hFFFF_FFFF;
    phase_thr[5] = 32'd1;
    foreach (phase_thr[i]) begin
      write_reg(ADDR_MIN_R2, phase_thr[i]);
      idle_on = (i % 3) != 2;
      random_states(80);
      drain();
    end
    idle_on = 1'b1;

    // let any stray result show up
    repeat (100) @(posedge clk);
    if (board.pending_jacobians.size() != 0) board.errors++;
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
